// File: hw/rtl/vrt_pkg.sv
// ----------------------------------------------------------------------------
// vrt_pkg: shared types and codes for the value remap table
// Request and status codes, the input and result words and the token that
// travels down the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package vrt_pkg;

  localparam int unsigned KEY_W = 64;

  typedef logic [1:0] req_t;
  typedef logic [2:0] status_t;

  // request codes; every other code is decoded as a clear
  localparam req_t REQ_INSERT = 2'd0;
  localparam req_t REQ_LOOKUP = 2'd1;
  localparam req_t REQ_CLEAR  = 2'd2;

  localparam status_t ST_STORED      = 3'd0;
  localparam status_t ST_HIT         = 3'd1;
  localparam status_t ST_MISS_DEF    = 3'd2;
  localparam status_t ST_MISS_PASS   = 3'd3;
  localparam status_t ST_FULL        = 3'd4;
  localparam status_t ST_CLEARED     = 3'd5;

  typedef struct packed {
    req_t             req_type;
    logic [KEY_W-1:0] key;
    logic             key_is_null;
    logic [KEY_W-1:0] new_value;
    logic             new_value_is_null;
    logic             use_dflt;
    logic [KEY_W-1:0] dflt_value;
    logic             default_is_null;
  } vrt_in_t;

  typedef struct packed {
    logic [KEY_W-1:0] result_value;
    logic             result_is_null;
    status_t          status;
  } vrt_out_t;

  // request in flight through the chain
  typedef struct packed {
    logic             valid;
    vrt_in_t          word;
    logic             done;      // hit found or slot written
    logic [KEY_W-1:0] res_value;
    logic             res_null;
  } vrt_tok_t;

endpackage : vrt_pkg

`default_nettype wire

// File: hw/rtl/vrt_cell.sv
// ----------------------------------------------------------------------------
// vrt_cell: one table entry of the remap chain
// Holds one key/value pair, serves the token passing by and registers the
// token for its right-hand neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module vrt_cell
  import vrt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     adv,
  input  wire vrt_tok_t tok_in,
  output vrt_tok_t      tok_out
);

  logic [KEY_W-1:0] key_r, key_nxt;
  logic [KEY_W-1:0] val_r, val_nxt;
  logic             vnull_r, vnull_nxt;
  logic             valid_r, valid_nxt;
  vrt_tok_t         tok_r, tok_nxt;
  logic             match;
  logic             live;

  assign match = valid_r && !tok_in.word.key_is_null && (key_r == tok_in.word.key);
  assign live  = tok_in.valid && !tok_in.done;

  always_comb begin
    key_nxt   = key_r;
    val_nxt   = val_r;
    vnull_nxt = vnull_r;
    valid_nxt = valid_r;
    tok_nxt   = tok_in;
    case (tok_in.word.req_type)
      REQ_INSERT: begin
        // entries fill from the left, so the first free cell is the lowest free slot
        if (live && !tok_in.word.key_is_null && (match || !valid_r)) begin
          key_nxt      = tok_in.word.key;
          val_nxt      = tok_in.word.new_value_is_null ? '0 : tok_in.word.new_value;
          vnull_nxt    = tok_in.word.new_value_is_null;
          valid_nxt    = 1'b1;
          tok_nxt.done = 1'b1;
        end
      end
      REQ_LOOKUP: begin
        if (live && match) begin
          tok_nxt.done      = 1'b1;
          tok_nxt.res_value = val_r;
          tok_nxt.res_null  = vnull_r;
        end
      end
      default: begin
        if (tok_in.valid) begin
          valid_nxt = 1'b0;
        end
      end
    endcase
  end

  // only the valid flags are reset; payload bits are qualified by them
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      tok_r.valid <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_nxt;
      key_r   <= key_nxt;
      val_r   <= val_nxt;
      vnull_r <= vnull_nxt;
      tok_r   <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule : vrt_cell

`default_nettype wire

// File: hw/rtl/vrt_tail.sv
// ----------------------------------------------------------------------------
// vrt_tail: end of the remap chain
// Keeps the null-key mapping, resolves hit/default/passthrough and holds the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module vrt_tail
  import vrt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     adv,
  input  wire vrt_tok_t tok_in,
  output logic          out_valid,
  output vrt_out_t      out_data
);

  logic             nk_mapped_r, nk_mapped_nxt;
  logic [KEY_W-1:0] nk_val_r, nk_val_nxt;
  logic             nk_null_r, nk_null_nxt;
  logic             out_valid_r;
  vrt_out_t         out_r, out_nxt;
  logic             hit;
  logic [KEY_W-1:0] hit_val;
  logic             hit_null;

  always_comb begin
    nk_mapped_nxt = nk_mapped_r;
    nk_val_nxt    = nk_val_r;
    nk_null_nxt   = nk_null_r;
    out_nxt       = '0;
    hit      = tok_in.word.key_is_null ? nk_mapped_r : tok_in.done;
    hit_val  = tok_in.word.key_is_null ? nk_val_r    : tok_in.res_value;
    hit_null = tok_in.word.key_is_null ? nk_null_r   : tok_in.res_null;
    case (tok_in.word.req_type)
      REQ_INSERT: begin
        if (tok_in.word.key_is_null) begin
          if (tok_in.valid) begin
            nk_mapped_nxt = 1'b1;
            nk_val_nxt    = tok_in.word.new_value_is_null ? '0 : tok_in.word.new_value;
            nk_null_nxt   = tok_in.word.new_value_is_null;
          end
          out_nxt.status = ST_STORED;
        end else begin
          out_nxt.status = tok_in.done ? ST_STORED : ST_FULL;
        end
      end
      REQ_LOOKUP: begin
        if (hit) begin
          out_nxt.status         = ST_HIT;
          out_nxt.result_is_null = hit_null;
          out_nxt.result_value   = hit_val;
        end else if (tok_in.word.use_dflt) begin
          out_nxt.status         = ST_MISS_DEF;
          out_nxt.result_is_null = tok_in.word.default_is_null;
          out_nxt.result_value   = tok_in.word.dflt_value;
        end else begin
          out_nxt.status         = ST_MISS_PASS;
          out_nxt.result_is_null = tok_in.word.key_is_null;
          out_nxt.result_value   = tok_in.word.key;
        end
        if (out_nxt.result_is_null) begin
          out_nxt.result_value = '0;
        end
      end
      default: begin
        if (tok_in.valid) begin
          nk_mapped_nxt = 1'b0;
          nk_val_nxt    = '0;
          nk_null_nxt   = 1'b0;
        end
        out_nxt.status = ST_CLEARED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nk_mapped_r <= 1'b0;
      nk_val_r    <= '0;
      nk_null_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      nk_mapped_r <= nk_mapped_nxt;
      nk_val_r    <= nk_val_nxt;
      nk_null_r   <= nk_null_nxt;
      out_valid_r <= tok_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule : vrt_tail

`default_nettype wire

// File: hw/rtl/value_remap_table.sv
// ----------------------------------------------------------------------------
// value_remap_table: key-to-value remap table built as a chain of cells
// Input words (in_valid/in_stall/in_data) carry insert, lookup or clear
// requests. Each word enters cell 0 and, while the chain is not frozen,
// moves one cell to the right per cycle; every cell owns one entry and
// compares it with the passing word. After the last cell the tail resolves
// null keys, defaults and passthrough and loads the output register
// (out_valid/out_stall/out_data).
// Throughput: one word per cycle while the chain moves; words follow each
// other down the chain and each cell sees the entry as left by the words ahead of it.
// Reset clears every entry's valid flag, the null-key mapping and all
// in-flight words at once; the block takes a word in the first cycle after.
// While out_stall holds a waiting result, the whole chain freezes and
// in_stall is raised; it drops as soon as the output register can move.
// ----------------------------------------------------------------------------
`default_nettype none

module value_remap_table
  import vrt_pkg::*;
#(
  parameter int unsigned ENTRIES = 64
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire vrt_in_t in_data,
  output logic         out_valid,
  input  wire logic    out_stall,
  output vrt_out_t     out_data
);

  logic     adv;
  vrt_tok_t head_tok;
  vrt_tok_t chain [ENTRIES+1];

  // chain moves whenever the output register is empty or being drained
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  always_comb begin
    head_tok           = '0;
    head_tok.valid     = in_valid;
    head_tok.word      = in_data;
  end

  assign chain[0] = head_tok;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    vrt_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .tok_in  (chain[g]),
      .tok_out (chain[g+1])
    );
  end

  vrt_tail u_tail (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .tok_in    (chain[ENTRIES]),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule : value_remap_table

`default_nettype wire

// File: bench/value_remap_table_test.sv
// ----------------------------------------------------------------------------
// value_remap_table_test: self-checking bench for the value remap table
// Sends insert, lookup and clear words through the valid/stall input channel,
// with random gaps on the input and random stalls on the result channel.
// A behavioral copy of the table predicts every result word, and the result
// words are checked in order, field by field. A short directed table covers
// the edge cases first. Random episodes follow: some fill the table past
// capacity, others mix requests over a small key pool.
// ----------------------------------------------------------------------------
module value_remap_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  import vrt_pkg::*;

  localparam int unsigned ENTRIES      = 64;
  localparam int unsigned LATENCY      = ENTRIES + 1;
  localparam int unsigned TARGET_WORDS = 500;

  // spare request code; the block decodes it as a clear
  localparam req_t REQ_SPARE = 2'd3;

  localparam logic [KEY_W-1:0] ALL_ONES = '1;
  localparam logic [KEY_W-1:0] TOP_BIT  = {1'b1, {(KEY_W-1){1'b0}}};

  // --------------------------------------------------------------------------
  // DUT hookup; every input starts at a known value
  // --------------------------------------------------------------------------
  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  vrt_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  vrt_out_t out_data;

  value_remap_table #(
    .ENTRIES(ENTRIES)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin : clock_gen
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Behavioral copy of the table. bit types start at zero, which matches the
  // reset state: no valid slot and no null-key mapping.
  // --------------------------------------------------------------------------
  bit [KEY_W-1:0] tbl_key   [ENTRIES];
  bit [KEY_W-1:0] tbl_val   [ENTRIES];
  bit             tbl_vnull [ENTRIES];
  bit             tbl_used  [ENTRIES];
  bit             nk_mapped;
  bit [KEY_W-1:0] nk_val;
  bit             nk_vnull;

  vrt_out_t    pending_results[$];   // predicted result words, oldest first
  int unsigned mismatch_count = 0;
  int unsigned words_sent     = 0;
  bit          drive_calm     = 1'b0; // no input gaps while set

  function automatic int find_slot(logic [KEY_W-1:0] k);
    for (int i = 0; i < ENTRIES; i++)
      if (tbl_used[i] && tbl_key[i] == k) return i;
    return -1;
  endfunction

  // Applies one request word to the table copy and returns its result word.
  function automatic vrt_out_t remap_predict(vrt_in_t w);
    vrt_out_t r;
    int       slot;
    bit       hit;
    r    = '0;
    slot = -1;
    hit  = 1'b0;
    case (w.req_type)
      REQ_INSERT: begin
        r.status = ST_STORED;
        if (w.key_is_null) begin
          // null key lives outside the slots and always lands
          nk_mapped = 1'b1;
          nk_val    = w.new_value_is_null ? '0 : w.new_value;
          nk_vnull  = w.new_value_is_null;
        end else begin
          slot = find_slot(w.key);
          if (slot < 0) begin
            // lowest free slot wins
            for (int i = ENTRIES - 1; i >= 0; i--)
              if (!tbl_used[i]) slot = i;
          end
          if (slot < 0) begin
            r.status = ST_FULL;
          end else begin
            tbl_key[slot]   = w.key;
            tbl_val[slot]   = w.new_value_is_null ? '0 : w.new_value;
            tbl_vnull[slot] = w.new_value_is_null;
            tbl_used[slot]  = 1'b1;
          end
        end
      end
      REQ_LOOKUP: begin
        if (w.key_is_null) begin
          if (nk_mapped) begin
            hit              = 1'b1;
            r.result_value   = nk_val;
            r.result_is_null = nk_vnull;
          end
        end else begin
          slot = find_slot(w.key);
          if (slot >= 0) begin
            hit              = 1'b1;
            r.result_value   = tbl_val[slot];
            r.result_is_null = tbl_vnull[slot];
          end
        end
        if (hit) begin
          r.status = ST_HIT;
        end else if (w.use_dflt) begin
          r.status         = ST_MISS_DEF;
          r.result_is_null = w.default_is_null;
          r.result_value   = w.dflt_value;
        end else begin
          // passthrough: the key itself, null included
          r.status         = ST_MISS_PASS;
          r.result_is_null = w.key_is_null;
          r.result_value   = w.key;
        end
        if (r.result_is_null) r.result_value = '0;
      end
      default: begin
        // clear and the spare code: drop all slots and the null-key mapping
        foreach (tbl_used[i]) tbl_used[i] = 1'b0;
        nk_mapped = 1'b0;
        nk_val    = '0;
        nk_vnull  = 1'b0;
        r.status  = ST_CLEARED;
      end
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Random helpers
  // --------------------------------------------------------------------------
  function automatic bit chance(int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // 64-bit value, leaning on the extremes now and then
  function automatic logic [KEY_W-1:0] rand_word();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return ALL_ONES;
      2:       return TOP_BIT;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // idle length: mostly none or short, a few long
  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic vrt_in_t make_word(req_t req, logic [KEY_W-1:0] key, bit kn,
                                        logic [KEY_W-1:0] nv, bit nvn, bit hd,
                                        logic [KEY_W-1:0] dv, bit dn);
    vrt_in_t w;
    w.req_type          = req;
    w.key               = key;
    w.key_is_null       = kn;
    w.new_value         = nv;
    w.new_value_is_null = nvn;
    w.use_dflt          = hd;
    w.dflt_value        = dv;
    w.default_is_null   = dn;
    return w;
  endfunction

  // request with random payload fields around a chosen key
  function automatic vrt_in_t random_word(req_t req, logic [KEY_W-1:0] key, bit kn);
    return make_word(req, key, kn, rand_word(), chance(15), chance(50),
                     rand_word(), chance(20));
  endfunction

  function automatic vrt_out_t result_of(logic [KEY_W-1:0] v, bit n, status_t st);
    vrt_out_t r;
    r.result_value   = v;
    r.result_is_null = n;
    r.status         = st;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Input side: optional gap, then hold the word until it is taken.
  // in_stall is read right at the edge, so it is the value the DUT saw.
  // The expectation is queued at the accepting edge; typed rows of the
  // directed table replace the predicted word with their own.
  // --------------------------------------------------------------------------
  task automatic issue_word(vrt_in_t w, bit typed, vrt_out_t typed_out);
    vrt_out_t    predicted;
    int unsigned gap;
    gap = pick_gap(drive_calm);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    predicted = remap_predict(w);
    pending_results.push_back(typed ? typed_out : predicted);
    words_sent++;
  endtask

  typedef struct {
    vrt_in_t  word;
    bit       typed;
    vrt_out_t result;
  } stim_row_t;

  stim_row_t directed_rows[$];

  task automatic add_row(vrt_in_t w, bit typed, vrt_out_t res);
    stim_row_t row;
    row.word   = w;
    row.typed  = typed;
    row.result = res;
    directed_rows.push_back(row);
  endtask

  // --------------------------------------------------------------------------
  // Result side: stall bursts, with calm stretches where nothing stalls
  // --------------------------------------------------------------------------
  initial begin : result_stall
    int unsigned n;
    bit          calm;
    forever begin
      calm = chance(20);
      repeat ($urandom_range(20, 120)) begin
        n = pick_gap(calm);
        if (n != 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  task automatic report_mismatch(string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // every word taken from the result channel is compared with the oldest
  // expectation
  always @(posedge clk) begin : result_check
    vrt_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result word with no pending request");
      end else begin
        want = pending_results.pop_front();
        if (out_data.result_value !== want.result_value)
          report_mismatch($sformatf("result_value %h, want %h",
                                    out_data.result_value, want.result_value));
        if (out_data.result_is_null !== want.result_is_null)
          report_mismatch($sformatf("result_is_null %b, want %b",
                                    out_data.result_is_null, want.result_is_null));
        if (out_data.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d",
                                    out_data.status, want.status));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [KEY_W-1:0] keys[$];
    logic [KEY_W-1:0] k;
    int unsigned      r;
    int unsigned      cap;
    req_t             req;
    bit               first_episode;

    // fresh table: everything misses
    add_row(make_word(REQ_LOOKUP, '0, 0, ALL_ONES, 0, 0, ALL_ONES, 0), 1,
            result_of('0, 0, ST_MISS_PASS));
    add_row(make_word(REQ_LOOKUP, ALL_ONES, 0, '0, 1, 1, ALL_ONES, 0), 1,
            result_of(ALL_ONES, 0, ST_MISS_DEF));
    add_row(make_word(REQ_LOOKUP, TOP_BIT, 0, '0, 0, 0, '0, 1), 1,
            result_of(TOP_BIT, 0, ST_MISS_PASS));
    // null key passes through as null; key bits are ignored
    add_row(make_word(REQ_LOOKUP, ALL_ONES, 1, '0, 0, 0, ALL_ONES, 0), 1,
            result_of('0, 1, ST_MISS_PASS));
    // null default: value bits come back as zero
    add_row(make_word(REQ_LOOKUP, ALL_ONES, 1, '0, 0, 1, ALL_ONES, 1), 1,
            result_of('0, 1, ST_MISS_DEF));
    add_row(make_word(REQ_LOOKUP, '0, 0, ALL_ONES, 1, 1, '0, 0), 1,
            result_of('0, 0, ST_MISS_DEF));
    // insert, then overwrite the same key with a null value
    add_row(make_word(REQ_INSERT, ALL_ONES, 0, 64'h0123_4567_89ab_cdef, 0, 1, ALL_ONES, 1),
            1, result_of('0, 0, ST_STORED));
    add_row(make_word(REQ_LOOKUP, ALL_ONES, 0, '0, 0, 0, '0, 0), 0, '0);
    add_row(make_word(REQ_INSERT, ALL_ONES, 0, ALL_ONES, 1, 0, '0, 0), 1,
            result_of('0, 0, ST_STORED));
    add_row(make_word(REQ_LOOKUP, ALL_ONES, 0, '0, 0, 1, TOP_BIT, 0), 0, '0);
    add_row(make_word(REQ_INSERT, '0, 0, ALL_ONES, 0, 0, '0, 0), 1,
            result_of('0, 0, ST_STORED));
    add_row(make_word(REQ_LOOKUP, '0, 0, '0, 0, 1, TOP_BIT, 1), 0, '0);
    // null-key mapping, set twice; never takes a slot
    add_row(make_word(REQ_INSERT, ALL_ONES, 1, TOP_BIT, 0, 0, '0, 0), 1,
            result_of('0, 0, ST_STORED));
    add_row(make_word(REQ_LOOKUP, '0, 1, '0, 0, 1, ALL_ONES, 0), 0, '0);
    add_row(make_word(REQ_INSERT, '0, 1, ALL_ONES, 1, 1, ALL_ONES, 1), 1,
            result_of('0, 0, ST_STORED));
    add_row(make_word(REQ_LOOKUP, '0, 1, '0, 0, 0, '0, 0), 0, '0);
    // clear drops slots and the null-key mapping; payload fields are noise
    add_row(make_word(REQ_CLEAR, ALL_ONES, 1, ALL_ONES, 1, 1, ALL_ONES, 1), 1,
            result_of('0, 0, ST_CLEARED));
    add_row(make_word(REQ_LOOKUP, ALL_ONES, 0, '0, 0, 0, '0, 0), 0, '0);
    add_row(make_word(REQ_LOOKUP, '0, 1, '0, 0, 0, '0, 0), 0, '0);
    add_row(make_word(REQ_INSERT, TOP_BIT, 0, 64'd1, 0, 0, '0, 0), 1,
            result_of('0, 0, ST_STORED));
    // spare code behaves as a clear
    add_row(make_word(REQ_SPARE, TOP_BIT, 0, ALL_ONES, 0, 1, ALL_ONES, 0), 1,
            result_of('0, 0, ST_CLEARED));
    add_row(make_word(REQ_LOOKUP, TOP_BIT, 0, '0, 0, 1, 64'h5a5a_a5a5_5a5a_a5a5, 0), 0, '0);

    // synchronous reset, held low from time zero, then released
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      issue_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].result);

    // random episodes until the word budget is spent
    first_episode = 1'b1;
    while (words_sent < TARGET_WORDS) begin
      drive_calm = chance(25);
      keys.delete();
      if (first_episode || chance(25)) begin
        // fill: clear, then insert distinct keys past capacity with a few
        // overwrites mixed in, then lookups and inserts on the full table
        issue_word(random_word(REQ_CLEAR, rand_word(), chance(50)), 0, '0);
        cap = ENTRIES + $urandom_range(2, 6);
        while (keys.size() < cap) begin
          if (keys.size() != 0 && chance(10)) begin
            k = keys[$urandom_range(0, keys.size() - 1)];
          end else begin
            k = {$urandom, $urandom};
            keys.push_back(k);
          end
          issue_word(random_word(REQ_INSERT, k, chance(3)), 0, '0);
        end
        repeat ($urandom_range(10, 20)) begin
          k   = chance(20) ? rand_word() : keys[$urandom_range(0, keys.size() - 1)];
          req = chance(30) ? REQ_INSERT : REQ_LOOKUP;
          issue_word(random_word(req, k, chance(5)), 0, '0);
        end
      end else begin
        // mixed traffic over a small key pool so lookups mostly hit
        repeat ($urandom_range(6, 14)) keys.push_back(rand_word());
        repeat ($urandom_range(20, 40)) begin
          r = $urandom_range(0, 99);
          if (r < 35)      req = REQ_INSERT;
          else if (r < 90) req = REQ_LOOKUP;
          else if (r < 97) req = REQ_CLEAR;
          else             req = REQ_SPARE;
          k = chance(80) ? keys[$urandom_range(0, keys.size() - 1)] : rand_word();
          issue_word(random_word(req, k, chance(10)), 0, '0);
        end
      end
      first_episode = 1'b0;
    end
    in_valid <= 1'b0;

    // drain, then give stray words time to show up
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // hard stop, far beyond the slowest legal run
  initial begin : watchdog
    #5ms;
    $display("simulation failed");
    $finish;
  end

endmodule
